/* rtl/n2a_pkg.sv */
// ----------------------------------------------------------------------------
// n2a_pkg: shared types and constants for the number to ASCII formatter
// Holds the channel structs, the command queue entry, the back-end states
// and the small helpers for digit weights and hex characters that the back end uses.
// ----------------------------------------------------------------------------
package n2a_pkg;

   // Format codes carried in the kind field of a request.
   localparam logic [1:0] KIND_UNSIGNED = 2'd0;
   localparam logic [1:0] KIND_SIGNED   = 2'd1;
   localparam logic [1:0] KIND_HEX      = 2'd2;
   localparam logic [1:0] KIND_UNUSED   = 2'd3;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // Command queue between the front end and the back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   // Digit positions handled by repeated subtraction.
   localparam logic [1:0] POS_TEN_THOUSANDS = 2'd0;
   localparam logic [1:0] POS_THOUSANDS     = 2'd1;
   localparam logic [1:0] POS_HUNDREDS      = 2'd2;
   localparam logic [1:0] POS_TENS          = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_UNSIGNED,
      CMD_SIGNED_POS,
      CMD_SIGNED_NEG,
      CMD_HEX
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [15:0]  magnitude;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic busy;
   } back_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREFIX,
      S_SUB,
      S_DIGIT,
      S_ONES,
      S_HEX_HI,
      S_HEX_LO
   } back_state_type;

   function automatic logic [15:0] digit_weight(input logic [1:0] pos);
      logic [15:0] w;
      begin
         unique case (pos)
            POS_TEN_THOUSANDS: w = 16'd10000;
            POS_THOUSANDS:     w = 16'd1000;
            POS_HUNDREDS:      w = 16'd100;
            default:           w = 16'd10;
         endcase
         return w;
      end
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] nib_ext;
      begin
         nib_ext = {4'h0, nib};
         if (nib <= 4'h9) begin
            return CHAR_ZERO + nib_ext;
         end else begin
            return CHAR_UPPER_A + nib_ext - 8'd10;
         end
      end
   endfunction

endpackage

/* rtl/n2a_front.sv */
// ----------------------------------------------------------------------------
// n2a_front: request intake and classification
// Accepts requests, turns signed values into sign plus magnitude, trims hex
// requests to the low byte and pushes one command per request. Requests of
// the unused kind are accepted and dropped.
// ----------------------------------------------------------------------------
module n2a_front import n2a_pkg::*; (
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   input  queue_status_type q_status,
   output logic             push,
   output cmd_type          push_data
);

   logic        accept;
   logic [15:0] negated;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign negated   = 16'(~req_data.value + 16'd1);

   always_comb begin
      push_data.kind      = CMD_UNSIGNED;
      push_data.magnitude = req_data.value;
      push                = 1'b0;
      unique case (req_data.kind)
         KIND_UNSIGNED: begin
            push = accept;
         end
         KIND_SIGNED: begin
            push = accept;
            if (req_data.value[15]) begin
               push_data.kind      = CMD_SIGNED_NEG;
               push_data.magnitude = negated;
            end else begin
               push_data.kind = CMD_SIGNED_POS;
            end
         end
         KIND_HEX: begin
            push                = accept;
            push_data.kind      = CMD_HEX;
            push_data.magnitude = {8'h00, req_data.value[7:0]};
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

endmodule

/* rtl/n2a_queue.sv */
// ----------------------------------------------------------------------------
// n2a_queue: command queue
// A short register queue that decouples classification from conversion.
// ----------------------------------------------------------------------------
module n2a_queue import n2a_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_data,
   input  logic             pop,
   output cmd_type          rd_data,
   output queue_status_type q_status
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_push, do_pop;

   function automatic logic [QUEUE_AW-1:0] next_ptr(input logic [QUEUE_AW-1:0] p);
      if (p == QUEUE_AW'(QUEUE_DEPTH - 1)) begin
         return '0;
      end else begin
         return p + QUEUE_AW'(1);
      end
   endfunction

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign rd_data        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/n2a_back.sv */
// ----------------------------------------------------------------------------
// n2a_back: conversion and character output
// Takes one command at a time, finds each decimal digit but the ones by repeated
// subtraction of its weight, and sends characters through an output register.
// ----------------------------------------------------------------------------
module n2a_back import n2a_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  cmd_type          rd_data,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   output back_status_type  bk_status
);

   back_state_type state_ff, state_in;
   cmd_kind_type   kind_ff, kind_in;
   logic [15:0]    rem_ff, rem_in;
   logic [1:0]     pos_ff, pos_in;
   logic [3:0]     dig_ff, dig_in;
   logic           started_ff, started_in;
   logic           out_valid_ff, out_valid_in;
   rsp_type        out_data_ff, out_data_in;

   logic           out_free;
   logic           ge_weight;
   logic [15:0]    weight;
   logic           show_digit;
   logic           emit;
   rsp_type        emit_data;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign weight     = digit_weight(pos_ff);
   assign ge_weight  = (rem_ff >= weight);
   assign show_digit = (dig_ff != 4'd0) || started_ff || (pos_ff == POS_TENS);

   assign rsp_valid      = out_valid_ff;
   assign rsp_data       = out_data_ff;
   assign bk_status.busy = (state_ff != S_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_status.empty) begin
               unique case (rd_data.kind)
                  CMD_HEX:      state_in = S_HEX_HI;
                  CMD_UNSIGNED: state_in = S_SUB;
                  default:      state_in = S_PREFIX;
               endcase
            end
         end
         S_PREFIX: begin
            if (out_free) state_in = S_SUB;
         end
         S_SUB: begin
            if (!ge_weight) state_in = S_DIGIT;
         end
         S_DIGIT: begin
            if (!show_digit || out_free) begin
               state_in = (pos_ff == POS_TENS) ? S_ONES : S_SUB;
            end
         end
         S_ONES: begin
            if (out_free) state_in = S_IDLE;
         end
         S_HEX_HI: begin
            if (out_free) state_in = S_HEX_LO;
         end
         S_HEX_LO: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      pop        = 1'b0;
      kind_in    = kind_ff;
      rem_in     = rem_ff;
      pos_in     = pos_ff;
      dig_in     = dig_ff;
      started_in = started_ff;
      emit       = 1'b0;
      emit_data  = '{character: CHAR_SPACE, last: 1'b0};
      unique case (state_ff)
         S_IDLE: begin
            if (!q_status.empty) begin
               pop        = 1'b1;
               kind_in    = rd_data.kind;
               rem_in     = rd_data.magnitude;
               pos_in     = POS_TEN_THOUSANDS;
               dig_in     = 4'd0;
               started_in = 1'b0;
            end
         end
         S_PREFIX: begin
            emit                = out_free;
            emit_data.character = (kind_ff == CMD_SIGNED_NEG) ? CHAR_MINUS : CHAR_SPACE;
         end
         S_SUB: begin
            if (ge_weight) begin
               rem_in = rem_ff - weight;
               dig_in = dig_ff + 4'd1;
            end
         end
         S_DIGIT: begin
            emit_data.character = CHAR_ZERO + {4'h0, dig_ff};
            emit                = show_digit && out_free;
            if (!show_digit || out_free) begin
               pos_in     = pos_ff + 2'd1;
               dig_in     = 4'd0;
               started_in = started_ff || show_digit;
            end
         end
         S_ONES: begin
            emit      = out_free;
            emit_data = '{character: CHAR_ZERO + {4'h0, rem_ff[3:0]}, last: 1'b1};
         end
         S_HEX_HI: begin
            emit                = out_free;
            emit_data.character = hex_char(rem_ff[7:4]);
         end
         S_HEX_LO: begin
            emit      = out_free;
            emit_data = '{character: hex_char(rem_ff[3:0]), last: 1'b1};
         end
         default: begin
            emit = 1'b0;
         end
      endcase

      if (emit) begin
         out_valid_in = 1'b1;
         out_data_in  = emit_data;
      end else begin
         out_valid_in = out_valid_ff && rsp_stall;
         out_data_in  = out_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      rem_ff      <= rem_in;
      pos_ff      <= pos_in;
      dig_ff      <= dig_in;
      started_ff  <= started_in;
      out_data_ff <= out_data_in;
   end

endmodule

/* rtl/number_to_ascii_formatter.sv */
// ----------------------------------------------------------------------------
// number_to_ascii_formatter: 16-bit number to ASCII character run
// Front end classifies requests into a two-entry command queue; the back end
// converts one command at a time and sends one character per transaction.
// ----------------------------------------------------------------------------
// The back end converts one command at a time; while it works, the front end keeps
// accepting requests until the command queue is full. Decimal digits come from the
// single subtract-and-compare unit, so a decimal item takes longer the larger its
// top four digits are; hex items do not use that unit.
// Synchronous reset empties the queue, idles the converter and drops any character.
module number_to_ascii_formatter import n2a_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   queue_status_type q_status;
   back_status_type  bk_status;
   logic             push;
   cmd_type          push_data;
   logic             pop;
   cmd_type          rd_data;

   n2a_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   n2a_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .rd_data   (rd_data),
      .q_status  (q_status)
   );

   n2a_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .rd_data   (rd_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .bk_status (bk_status)
   );

   // The queue can never report empty and full together.
   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_status.empty && q_status.full))
      else $error("command queue reports empty and full");

   // An accepted request of a formatted kind always leaves a command in the queue.
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.kind != KIND_UNUSED)) |=> !q_status.empty)
      else $error("accepted request did not reach the command queue");

   // After a non-final character goes out, the run is still in progress.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last) |=> (bk_status.busy || rsp_valid))
      else $error("character run ended without a final character");

endmodule
